@@ design/matrix4_vector_transform_defines.svh @@
// Assertion macros used by the transform block's back end.
`ifndef MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define M4VT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define M4VT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/m4vt_pkg.sv @@
// Shared types and constants for the 4x4 matrix vector transform block.
package m4vt_pkg;

    // Word and fixed point widths
    localparam int WORD_BITS = 32;
    localparam int VEC_BITS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int ELEM_BITS = (WORD_BITS < VEC_BITS) ? WORD_BITS : VEC_BITS;
    localparam int PROD_BITS = ELEM_BITS + VEC_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_MAT_COL = 2'd1;
    localparam logic [1:0] CMD_ROW_MAT = 2'd2;

    // Saturation bounds of a result element
    localparam logic signed [ELEM_BITS-1:0] RES_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
    localparam logic signed [ELEM_BITS-1:0] RES_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};

    typedef logic signed [VEC_BITS-1:0]  t_word;
    typedef logic signed [ELEM_BITS-1:0] t_elem;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [SUM_BITS-1:0]  t_sum;

    // Operation carried through the queue
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_COL  = 2'd1,
        OP_ROW  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] row;
        t_word [3:0] vec;
    } t_qitem;

endpackage

@@ design/m4vt_if.sv @@
// Item channel interfaces: input commands and transform results.
interface m4vt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  row_index;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;

    modport source (output valid, command, row_index, vec_x, vec_y, vec_z, vec_w,
                    input ready);
    modport sink   (input valid, command, row_index, vec_x, vec_y, vec_z, vec_w,
                    output ready);
endinterface

interface m4vt_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic        saturated;

    modport source (output valid, res_x, res_y, res_z, res_w, saturated, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_w, saturated, output ready);
endinterface

@@ design/m4vt_front.sv @@
// Front end: accepts input items, classifies the command and pushes work to the queue.
module m4vt_front (
    m4vt_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output m4vt_pkg::t_qitem  o_item
);
    import m4vt_pkg::*;

    logic w_keep;
    t_op  w_op;

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;

    // Classify; the unused command code is accepted and dropped
    always_comb begin
        w_keep = 1'b1;
        w_op   = OP_LOAD;
        case (i_in.command)
            CMD_LOAD:    w_op   = OP_LOAD;
            CMD_MAT_COL: w_op   = OP_COL;
            CMD_ROW_MAT: w_op   = OP_ROW;
            default:     w_keep = 1'b0;
        endcase
    end

    assign o_item.op     = w_op;
    assign o_item.row    = i_in.row_index;
    assign o_item.vec[0] = i_in.vec_x;
    assign o_item.vec[1] = i_in.vec_y;
    assign o_item.vec[2] = i_in.vec_z;
    assign o_item.vec[3] = i_in.vec_w;
    assign o_push        = i_in.valid && !i_full && w_keep;

endmodule

@@ design/m4vt_queue.sv @@
// Short FIFO that decouples the front end from the compute back end.
module m4vt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  m4vt_pkg::t_qitem  i_item,
    output logic              o_full,
    output logic              o_valid,
    output m4vt_pkg::t_qitem  o_item,
    input  logic              i_pop
);
    import m4vt_pkg::*;

    t_qitem                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_BITS-1:0] r_head, n_head;
    logic [QUEUE_IDX_BITS-1:0] r_tail, n_tail;
    logic [QUEUE_CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];

    // Pointer and fill count updates
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head  = (r_head == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

endmodule

@@ design/m4vt_back.sv @@
// Back end: holds the matrix, applies row loads and runs the three-stage transform pipe.
`include "matrix4_vector_transform_defines.svh"

module m4vt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  m4vt_pkg::t_qitem  i_item,
    output logic              o_pop,
    m4vt_out_if.source        o_out
);
    import m4vt_pkg::*;

    t_elem r_mat [4][4];
    t_prod r_prod [4][4];
    t_sum  r_sum [4];
    t_elem r_res [4];
    logic  r_sat;
    logic  r_v1, r_v2, r_v3;

    logic  w_en1, w_en2, w_en3;
    logic  w_is_load, w_take;
    t_prod w_prod [4][4];
    t_sum  w_sum [4];
    t_sum  w_shift [4];
    t_elem w_res [4];
    logic [3:0] w_clip;

    // Stage enables: a stage moves when empty or when its successor moves
    assign w_en3     = !r_v3 || o_out.ready;
    assign w_en2     = !r_v2 || w_en3;
    assign w_en1     = !r_v1 || w_en2;
    assign w_is_load = (i_item.op == OP_LOAD);
    assign o_pop     = i_valid && (w_is_load || w_en1);
    assign w_take    = i_valid && !w_is_load && w_en1;

    // Row load into the matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (o_pop && w_is_load) begin
            for (int c = 0; c < 4; c++) begin
                r_mat[i_item.row][c] <= i_item.vec[c][ELEM_BITS-1:0];
            end
        end
    end

    // Stage 1 products: matrix row or column times the vector
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (i_item.op == OP_COL) begin
                    w_prod[i][j] = PROD_BITS'(r_mat[i][j]) * PROD_BITS'(i_item.vec[j]);
                end else begin
                    w_prod[i][j] = PROD_BITS'(r_mat[j][i]) * PROD_BITS'(i_item.vec[j]);
                end
            end
        end
    end

    // Stage 2 full-width sums
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sum[i] = SUM_BITS'(r_prod[i][0]) + SUM_BITS'(r_prod[i][1])
                     + SUM_BITS'(r_prod[i][2]) + SUM_BITS'(r_prod[i][3]);
        end
    end

    // Stage 3 floor shift back to Q16.16 and saturate
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_shift[i] = r_sum[i] >>> FRAC_BITS;
            w_clip[i]  = 1'b1;
            if (w_shift[i] > SUM_BITS'(RES_MAX)) begin
                w_res[i] = RES_MAX;
            end else if (w_shift[i] < SUM_BITS'(RES_MIN)) begin
                w_res[i] = RES_MIN;
            end else begin
                w_res[i]  = w_shift[i][ELEM_BITS-1:0];
                w_clip[i] = 1'b0;
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_take;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod <= w_prod;
        end
        if (w_en2 && r_v1) begin
            r_sum <= w_sum;
        end
        if (w_en3 && r_v2) begin
            r_res <= w_res;
            r_sat <= |w_clip;
        end
    end

    // Result channel
    assign o_out.valid     = r_v3;
    assign o_out.res_x     = 32'(r_res[0]);
    assign o_out.res_y     = 32'(r_res[1]);
    assign o_out.res_z     = 32'(r_res[2]);
    assign o_out.res_w     = 32'(r_res[3]);
    assign o_out.saturated = r_sat;

    `M4VT_ASSERT_NXT(a_s1_hold, r_v1 && !w_en2, r_v1, "stage 1 lost an item under stall")
    `M4VT_ASSERT_NXT(a_s2_hold, r_v2 && !w_en3, r_v2 && $stable(r_sum[0]), "stage 2 changed under stall")
    `M4VT_ASSERT_IMP(a_sat_bound, r_v3 && r_sat, (r_res[0] == RES_MAX) || (r_res[0] == RES_MIN) || (r_res[1] == RES_MAX) || (r_res[1] == RES_MIN) || (r_res[2] == RES_MAX) || (r_res[2] == RES_MIN) || (r_res[3] == RES_MAX) || (r_res[3] == RES_MIN), "saturation flag without a clipped element")

endmodule

@@ design/matrix4_vector_transform.sv @@
// Top level of the 4x4 matrix vector transform: front end, queue and back end.
// A result passes the queue and the stage 1, 2 and 3 registers. Throughput: one item per cycle
// when the output does not stall; the 16 multipliers of stage 1 take a new vector every cycle.
// Row loads take effect for every transform accepted after them and give no result.
// Reset clears the matrix to zero and empties the queue and the pipeline.
module matrix4_vector_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m4vt_in_if.sink     i_in,
    m4vt_out_if.source  o_out
);
    import m4vt_pkg::*;

    logic   w_push, w_full, w_qvalid, w_pop;
    t_qitem w_push_item, w_pop_item;

    m4vt_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_push_item)
    );

    m4vt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_item  (w_pop_item),
        .i_pop   (w_pop)
    );

    m4vt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
